### rtl/jpeg_quality_quantiser_macros.svh
// Assertion macros used by the quantiser RTL (jqq_quant).
`ifndef JPEG_QUALITY_QUANTISER_MACROS_SVH
`define JPEG_QUALITY_QUANTISER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JQQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JQQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jqq_pkg.sv
// Shared constants, base tables and port structs of the quantiser.
package jqq_pkg;

  localparam int COEFF_WIDTH = 11;
  localparam int OUT_W       = 11;
  localparam int POS_W       = 6;
  localparam int TBL_AW      = POS_W + 1;
  localparam int TBL_DEPTH   = 1 << TBL_AW;
  localparam int BASE_W      = 7;
  localparam int Q_W         = 7;
  localparam int S_W         = 13;
  localparam int D_W         = 13;
  localparam int DD_W        = D_W + 1;
  localparam int NUM_W       = ((COEFF_WIDTH + 1 > D_W) ? COEFF_WIDTH + 1 : D_W) + 1;
  localparam int REC_W       = NUM_W;
  localparam int PRD_W       = 20;
  localparam int DVD_W       = (PRD_W > NUM_W + 1) ? PRD_W : NUM_W + 1;
  localparam int DVS_W       = DD_W;

  // x / 100 as (x * DIV100_MUL) >> DIV100_SH, exact for any PRD_W-bit x
  localparam int DIV100_SH   = 27;
  localparam int DIV100_W    = 21;

  localparam int IN_TDATA_W  = ((COEFF_WIDTH + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [Q_W-1:0]      Q_MIN      = Q_W'(1);
  localparam logic [Q_W-1:0]      Q_MAX      = Q_W'(100);
  localparam logic [Q_W-1:0]      Q_KNEE     = Q_W'(50);
  localparam logic [Q_W-1:0]      Q_RESET    = Q_W'(50);
  localparam logic [DVD_W-1:0]    S_NUM      = DVD_W'(5000);
  localparam logic [S_W-1:0]      S_OFS      = S_W'(200);
  localparam logic [PRD_W-1:0]    ROUND_OFS  = PRD_W'(50);
  localparam logic [DIV100_W-1:0] DIV100_MUL = DIV100_W'(1342178);
  localparam logic [DVD_W-1:0]    RECIP_NUM  = DVD_W'(1) << NUM_W;

  localparam logic [BASE_W-1:0] BASE_LUMA [64] = '{
    7'd16,  7'd11,  7'd10,  7'd16,  7'd24,  7'd40,  7'd51,  7'd61,
    7'd12,  7'd12,  7'd14,  7'd19,  7'd26,  7'd58,  7'd60,  7'd55,
    7'd14,  7'd13,  7'd16,  7'd24,  7'd40,  7'd57,  7'd69,  7'd56,
    7'd14,  7'd17,  7'd22,  7'd29,  7'd51,  7'd87,  7'd80,  7'd62,
    7'd18,  7'd22,  7'd37,  7'd56,  7'd68,  7'd109, 7'd103, 7'd77,
    7'd24,  7'd35,  7'd55,  7'd64,  7'd81,  7'd104, 7'd113, 7'd92,
    7'd49,  7'd64,  7'd78,  7'd87,  7'd103, 7'd121, 7'd120, 7'd101,
    7'd72,  7'd92,  7'd95,  7'd98,  7'd112, 7'd100, 7'd103, 7'd99
  };

  localparam logic [BASE_W-1:0] BASE_CHROMA [64] = '{
    7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
  };

  // Table index is {is_chroma, position}.
  function automatic logic [BASE_W-1:0] base_entry(input logic [TBL_AW-1:0] idx);
    logic [BASE_W-1:0] b;
    if (idx[TBL_AW-1]) b = BASE_CHROMA[idx[POS_W-1:0]];
    else               b = BASE_LUMA[idx[POS_W-1:0]];
    return b;
  endfunction

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] addr;
    logic [DD_W-1:0]   dd;
    logic [REC_W-1:0]  rec;
  } tbl_wr_t;

endpackage

### rtl/jpeg_quality_quantiser.sv
// JPEG quantiser top level: quality register, table builder and divide pipeline.
//
// Quantises one signed DCT coefficient per word against the standard luma or
// chroma table entry at its position, scaled by the quality register, and
// rounds the quotient to nearest with ties away from zero. Sustained rate is
// one word per clock while m_axis_tready is high and no rebuild holds the
// input; a word passes the three pipeline stages and the output register on
// its way to the master side, and the ready chain through them lets the input
// keep filling empty stages while a result waits. The scaled divisors and their
// reciprocals live in a 128-word table memory that is rebuilt after reset and
// after every quality write; the divide by 100 is a reciprocal multiply, the
// scale factor and the reciprocals go through a shared bit-serial divider, and
// s_axis_tready stays low for the whole rebuild. Quality writes must go in
// only while no words are in flight; the block itself does not enforce it.
module jpeg_quality_quantiser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // quality register write
  input  logic                               cfg_we_i,
  input  logic [jqq_pkg::Q_W-1:0]            cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: coefficient, position
  input  logic [jqq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: is_chroma
  input  logic [0:0]                         s_axis_tuser,
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: quantised
  output logic [jqq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int W  = jqq_pkg::COEFF_WIDTH;
  localparam int PW = jqq_pkg::POS_W;

  logic [jqq_pkg::Q_W-1:0]    quality_q;
  logic                       fill_busy, hold;
  jqq_pkg::tbl_wr_t           tbl_wr;
  logic signed [jqq_pkg::OUT_W-1:0] quantised;

  // quality register; reset value matches the standard tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quality_q <= jqq_pkg::Q_RESET;
    end else if (cfg_we_i) begin
      quality_q <= cfg_wdata_i;
    end
  end

  // no words while the table is being rebuilt
  assign hold = fill_busy || cfg_we_i;

  jqq_fill u_fill (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .quality_i (quality_q),
    .wr_o      (tbl_wr),
    .busy_o    (fill_busy)
  );

  jqq_quant u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (tbl_wr),
    .hold_i      (hold),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .coeff_i     (s_axis_tdata[W-1:0]),
    .position_i  (s_axis_tdata[W+PW-1:W]),
    .is_chroma_i (s_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .quantised_o (quantised)
  );

  assign m_axis_tdata = {{(jqq_pkg::OUT_TDATA_W - jqq_pkg::OUT_W){1'b0}}, quantised};

endmodule

### rtl/jqq_div.sv
// Restoring divider, one quotient bit per cycle; a start restarts it.
module jqq_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jqq_pkg::div_req_t req_i,
  output jqq_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(jqq_pkg::DVD_W + 1);

  logic                        busy_q, done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [jqq_pkg::DVS_W-1:0]   rem_q, dvs_q;
  logic [jqq_pkg::DVD_W-1:0]   dvd_q;
  logic [jqq_pkg::DVS_W:0]     rem_sh, rem_diff;
  logic                        ge;

  assign rem_sh   = {rem_q, dvd_q[jqq_pkg::DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs_q};
  assign rem_diff = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(jqq_pkg::DVD_W);
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_diff[jqq_pkg::DVS_W-1:0];
      dvd_q <= {dvd_q[jqq_pkg::DVD_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

### rtl/jqq_fill.sv
// Table builder: scales the base tables by quality into divisor/reciprocal words.
module jqq_fill (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      restart_i,
  input  logic [jqq_pkg::Q_W-1:0]   quality_i,
  output jqq_pkg::tbl_wr_t          wr_o,
  output logic                      busy_o
);

  localparam int DPW = jqq_pkg::DIV100_SH + jqq_pkg::D_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b000_0001,
    ST_SCALE = 7'b000_0010,
    ST_SWAIT = 7'b000_0100,
    ST_PROD  = 7'b000_1000,
    ST_DIVD  = 7'b001_0000,
    ST_RECIP = 7'b010_0000,
    ST_RWAIT = 7'b100_0000
  } fill_state_e;

  fill_state_e                    state_q, state_d;
  logic [jqq_pkg::TBL_AW-1:0]     idx_q, idx_d;
  logic [jqq_pkg::S_W-1:0]        s_q, s_d, s_lin;
  logic [jqq_pkg::PRD_W-1:0]      prod_q, prod_d;
  logic [jqq_pkg::DD_W-1:0]       dd_q, dd_d;
  logic [jqq_pkg::Q_W-1:0]        qc;
  logic [DPW-1:0]                 d_prod;
  logic [jqq_pkg::D_W-1:0]        d_raw;
  logic [jqq_pkg::BASE_W-1:0]     base;
  logic                           qual_low;
  jqq_pkg::div_req_t              div_req;
  jqq_pkg::div_rsp_t              div_rsp;

  jqq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (quality_i < jqq_pkg::Q_MIN)      qc = jqq_pkg::Q_MIN;
    else if (quality_i > jqq_pkg::Q_MAX) qc = jqq_pkg::Q_MAX;
    else                                 qc = quality_i;
  end

  assign qual_low = qc < jqq_pkg::Q_KNEE;
  assign s_lin    = jqq_pkg::S_OFS - jqq_pkg::S_W'({qc, 1'b0});
  assign base     = jqq_pkg::base_entry(idx_q);
  // divide by 100 through a reciprocal multiply
  assign d_prod   = DPW'(prod_q) * DPW'(jqq_pkg::DIV100_MUL);
  assign d_raw    = d_prod[jqq_pkg::DIV100_SH +: jqq_pkg::D_W];

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = jqq_pkg::RECIP_NUM;
    div_req.divisor  = dd_q;
    case (state_q)
      ST_SCALE: begin
        div_req.start    = qual_low;
        div_req.dividend = jqq_pkg::S_NUM;
        div_req.divisor  = jqq_pkg::DVS_W'(qc);
      end
      ST_RECIP: begin
        div_req.start    = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    s_d     = s_q;
    prod_d  = prod_q;
    dd_d    = dd_q;
    case (state_q)
      ST_IDLE: ;
      ST_SCALE: begin
        idx_d = '0;
        if (qual_low) begin
          state_d = ST_SWAIT;
        end else begin
          s_d     = s_lin;
          state_d = ST_PROD;
        end
      end
      ST_SWAIT: begin
        if (div_rsp.done) begin
          s_d     = div_rsp.quotient[jqq_pkg::S_W-1:0];
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        prod_d  = jqq_pkg::PRD_W'(s_q) * jqq_pkg::PRD_W'(base) + jqq_pkg::ROUND_OFS;
        state_d = ST_DIVD;
      end
      ST_DIVD: begin
        // quality 100 scales to zero; keep the divisor at one
        if (d_raw == '0) dd_d = jqq_pkg::DD_W'(2);
        else             dd_d = {d_raw, 1'b0};
        state_d = ST_RECIP;
      end
      ST_RECIP: state_d = ST_RWAIT;
      ST_RWAIT: begin
        if (div_rsp.done) begin
          if (idx_q == jqq_pkg::TBL_AW'(jqq_pkg::TBL_DEPTH - 1)) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + jqq_pkg::TBL_AW'(1);
            state_d = ST_PROD;
          end
        end
      end
      default: state_d = ST_SCALE;
    endcase
    if (restart_i) state_d = ST_SCALE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SCALE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    prod_q <= prod_d;
    dd_q   <= dd_d;
  end

  assign wr_o.we   = (state_q == ST_RWAIT) && div_rsp.done && !restart_i;
  assign wr_o.addr = idx_q;
  assign wr_o.dd   = dd_q;
  assign wr_o.rec  = div_rsp.quotient[jqq_pkg::REC_W-1:0];
  assign busy_o    = state_q != ST_IDLE;

endmodule

### rtl/jqq_quant.sv
// Divisor table memory and the four-stage reciprocal divide pipeline.
`include "jpeg_quality_quantiser_macros.svh"

module jqq_quant (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  jqq_pkg::tbl_wr_t                    wr_i,
  input  logic                                hold_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [jqq_pkg::COEFF_WIDTH-1:0] coeff_i,
  input  logic [jqq_pkg::POS_W-1:0]           position_i,
  input  logic                                is_chroma_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [jqq_pkg::OUT_W-1:0]    quantised_o
);

  localparam int W   = jqq_pkg::COEFF_WIDTH;
  localparam int NW  = jqq_pkg::NUM_W;
  localparam int DW  = jqq_pkg::DD_W;
  localparam int RW  = jqq_pkg::REC_W;
  localparam int MW  = NW + DW;
  localparam int OW  = jqq_pkg::OUT_W;
  localparam logic [NW-1:0] NEG_LIM = NW'(1) << (OW - 1);
  localparam logic [NW-1:0] POS_LIM = NEG_LIM - NW'(1);

  logic [DW+RW-1:0] mem_q [jqq_pkg::TBL_DEPTH];

  logic acc, rdy0, rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q, ov_q;

  // stage 1: table word and magnitude
  logic [DW+RW-1:0] rd_q;
  logic [W-1:0]     mag1_q, raw, mag;
  logic             neg1_q;
  logic [DW-1:0]    dd1;
  logic [RW-1:0]    rec1;
  logic [NW-1:0]    n1;
  // stage 2: estimate product
  logic [NW-1:0]    n2_q;
  logic [DW-1:0]    dd2_q;
  logic             neg2_q;
  logic [2*NW-1:0]  p2_q;
  logic [NW-1:0]    q0;
  // stage 3: back-multiply
  logic [NW-1:0]    n3_q, q3_q;
  logic [DW-1:0]    dd3_q;
  logic             neg3_q;
  logic [MW-1:0]    m3_q;
  logic             fix;
  logic [NW-1:0]    qmag, qsat;
  logic [OW-1:0]    qlow;
  logic signed [OW-1:0] res, out_q;

  assign rdy3       = !ov_q || out_ready_i;
  assign rdy2       = !v3_q || rdy3;
  assign rdy1       = !v2_q || rdy2;
  assign rdy0       = !v1_q || rdy1;
  assign in_ready_o = rdy0 && !hold_i;
  assign acc        = in_valid_i && in_ready_o;

  assign raw = coeff_i;
  assign mag = raw[W-1] ? (~raw + W'(1)) : raw;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem_q[wr_i.addr] <= {wr_i.dd, wr_i.rec};
  end

  always_ff @(posedge clk_i) begin
    if (acc) rd_q <= mem_q[{is_chroma_i, position_i}];
  end

  assign dd1  = rd_q[DW+RW-1:RW];
  assign rec1 = rd_q[RW-1:0];
  assign n1   = NW'({mag1_q, 1'b0}) + NW'(dd1[DW-1:1]);
  assign q0   = p2_q[2*NW-1:NW];

  always_comb begin
    fix  = {1'b0, MW'(n3_q)} >= ({1'b0, m3_q} + (MW + 1)'(dd3_q));
    qmag = q3_q + NW'(fix);
    if (neg3_q) qsat = (qmag > NEG_LIM) ? NEG_LIM : qmag;
    else        qsat = (qmag > POS_LIM) ? POS_LIM : qmag;
    qlow = qsat[OW-1:0];
    res  = neg3_q ? OW'(~qlow + OW'(1)) : qlow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (rdy0) v1_q <= acc;
      if (rdy1) v2_q <= v1_q;
      if (rdy2) v3_q <= v2_q;
      if (rdy3) ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mag1_q <= mag;
      neg1_q <= raw[W-1];
    end
    if (rdy1) begin
      n2_q   <= n1;
      dd2_q  <= dd1;
      neg2_q <= neg1_q;
      p2_q   <= (2 * NW)'(n1) * (2 * NW)'(rec1);
    end
    if (rdy2) begin
      n3_q   <= n2_q;
      dd3_q  <= dd2_q;
      neg3_q <= neg2_q;
      q3_q   <= q0;
      m3_q   <= MW'(q0) * MW'(dd2_q);
    end
    if (rdy3) out_q <= res;
  end

  assign out_valid_o = ov_q;
  assign quantised_o = out_q;

  `JQQ_ASSERT_IMPL(a_no_rd_wr_clash, acc, !wr_i.we, "item accepted during table write")
  `JQQ_ASSERT_NEXT(a_accept_fills_s1, acc, v1_q, "accepted word missing in stage 1")
  `JQQ_ASSERT_IMPL(a_est_not_high, v3_q, (m3_q <= MW'(n3_q)), "quotient estimate too high")
  `JQQ_ASSERT_IMPL(a_est_not_low, v3_q, ({1'b0, MW'(n3_q)} < ({1'b0, m3_q} + (MW + 1)'({dd3_q, 1'b0}))), "quotient estimate low by more than one")

endmodule

### bench/tb_top.sv
// Self-checking bench for the quality-scaled JPEG quantiser: random stream traffic across settings.
`timescale 1ns / 1ps

module tb_top;

  localparam int COEF_W = jqq_pkg::COEFF_WIDTH;
  localparam int LVL_W  = jqq_pkg::OUT_W;
  localparam int LVL_MIN = -1024;
  localparam int LVL_MAX = 1023;
  // drain wait after the queues empty; covers the result pipeline with margin
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 98;

  // Annex K base tables, row-major
  localparam int LUMA_BASE [64] = '{
    16, 11, 10, 16, 24, 40, 51, 61,
    12, 12, 14, 19, 26, 58, 60, 55,
    14, 13, 16, 24, 40, 57, 69, 56,
    14, 17, 22, 29, 51, 87, 80, 62,
    18, 22, 37, 56, 68, 109, 103, 77,
    24, 35, 55, 64, 81, 104, 113, 92,
    49, 64, 78, 87, 103, 121, 120, 101,
    72, 92, 95, 98, 112, 100, 103, 99
  };
  localparam int CHROMA_BASE [64] = '{
    17, 18, 24, 47, 99, 99, 99, 99,
    18, 21, 26, 66, 99, 99, 99, 99,
    24, 26, 56, 99, 99, 99, 99, 99,
    47, 66, 99, 99, 99, 99, 99, 99,
    99, 99, 99, 99, 99, 99, 99, 99,
    99, 99, 99, 99, 99, 99, 99, 99,
    99, 99, 99, 99, 99, 99, 99, 99,
    99, 99, 99, 99, 99, 99, 99, 99
  };

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [jqq_pkg::POS_W-1:0] pos;
    logic                      chroma;
  } coeff_word_t;

  typedef struct packed {
    coeff_word_t      src;
    logic [LVL_W-1:0] level;
  } level_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           cfg_we_i = 1'b0;
  logic [jqq_pkg::Q_W-1:0]        cfg_wdata_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // tdata: coefficient [10:0], position [16:11], zero pad above
  logic [jqq_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  // tuser: is_chroma
  logic [0:0]                     s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b1;
  // tdata: quantised [10:0], zero pad above
  logic [jqq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  coeff_word_t  coeff_backlog [$];
  level_entry_t want_levels [$];
  logic [jqq_pkg::Q_W-1:0] quality_shadow = jqq_pkg::Q_W'(50);

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned levels_checked = 0;
  int unsigned phases_run = 0;
  int unsigned drv_wait = 0;
  int unsigned drv_gap;
  bit          drv_calm = 1'b0;
  int unsigned mon_wait = 0;
  int unsigned mon_stall;
  bit          mon_calm = 1'b0;

  always #5 clk_i = ~clk_i;

  jpeg_quality_quantiser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Scale the base entry by quality, then divide with rounding half away from zero.
  function automatic logic [LVL_W-1:0] quant_level(input coeff_word_t w,
                                                   input logic [jqq_pkg::Q_W-1:0] qual);
    int q;
    int s;
    int base;
    int step;
    int mag;
    int qmag;
    int res;
    q = qual;
    if (q < 1) q = 1;        // quality zero acts as one
    if (q > 100) q = 100;    // above one hundred acts as one hundred
    s = (q < 50) ? 5000 / q : 200 - 2 * q;
    base = w.chroma ? CHROMA_BASE[w.pos] : LUMA_BASE[w.pos];
    step = (s * base + 50) / 100;
    if (step < 1) step = 1;  // quality 100 would give a zero step
    mag = int'(w.coef);
    if (mag < 0) mag = -mag;
    qmag = (2 * mag + step) / (2 * step);
    res = (w.coef < 0) ? -qmag : qmag;
    if (res < LVL_MIN) res = LVL_MIN;
    if (res > LVL_MAX) res = LVL_MAX;
    return res[LVL_W-1:0];
  endfunction

  task automatic push_word(input int coef, input int pos, input int chroma);
    coeff_word_t w;
    w.coef = coef[COEF_W-1:0];
    w.pos = pos[jqq_pkg::POS_W-1:0];
    w.chroma = chroma[0];
    coeff_backlog.push_back(w);
  endtask

  // Driver: presents the head of the backlog, random gap after each accepted word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want_levels.push_back('{src: coeff_backlog[0],
                                level: quant_level(coeff_backlog[0], quality_shadow)});
        void'(coeff_backlog.pop_front());
        words_sent++;
        if ($urandom_range(0, 31) == 0) drv_calm = !drv_calm;
        drv_gap = drv_calm ? 0 : $urandom_range(0, 14);
        if (drv_gap == 0 && coeff_backlog.size() > 0) begin
          // back-to-back: valid stays high
          s_axis_tdata <= jqq_pkg::IN_TDATA_W'({coeff_backlog[0].pos, coeff_backlog[0].coef});
          s_axis_tuser <= coeff_backlog[0].chroma;
        end else begin
          s_axis_tvalid <= 1'b0;
          drv_wait <= drv_gap;
        end
      end else if (!s_axis_tvalid) begin
        if (drv_wait > 0) begin
          drv_wait <= drv_wait - 1;
        end else if (coeff_backlog.size() > 0) begin
          s_axis_tdata <= jqq_pkg::IN_TDATA_W'({coeff_backlog[0].pos, coeff_backlog[0].coef});
          s_axis_tuser <= coeff_backlog[0].chroma;
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks each accepted level against the oldest prediction, random stall after.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_levels.size() == 0) begin
          $display("%0t: level %0d with no word pending", $time,
                   $signed(m_axis_tdata[LVL_W-1:0]));
          mismatches++;
        end else begin
          if (m_axis_tdata[LVL_W-1:0] !== want_levels[0].level) begin
            $display("%0t: coef %0d pos %0d chroma %0b q %0d: expected %0d, actual %0d",
                     $time, want_levels[0].src.coef, want_levels[0].src.pos,
                     want_levels[0].src.chroma, quality_shadow,
                     $signed(want_levels[0].level), $signed(m_axis_tdata[LVL_W-1:0]));
            mismatches++;
          end
          void'(want_levels.pop_front());
          levels_checked++;
        end
        if ($urandom_range(0, 31) == 0) mon_calm = !mon_calm;
        mon_stall = mon_calm ? 0 : $urandom_range(0, 14);
        if (mon_stall > 0) begin
          m_axis_tready <= 1'b0;
          mon_wait <= mon_stall;
        end
      end else if (!m_axis_tready) begin
        if (mon_wait <= 1) m_axis_tready <= 1'b1;
        else mon_wait <= mon_wait - 1;
      end
    end
  end

  initial begin
    int unsigned quality_plan [$];
    int unsigned k;
    int unsigned n;
    int coef;
    quality_plan = '{1, 100, 0, 127, 49, 51, 99, 2};
    for (k = 0; k < 4; k++) quality_plan.push_back($urandom_range(0, 127));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first phase runs at the reset quality; directed words first
    push_word(-1024, 0, 0);
    push_word(1023, 0, 0);
    push_word(-1024, 63, 1);
    push_word(1023, 63, 1);
    push_word(0, 0, 0);
    push_word(0, 63, 1);
    push_word(1, 0, 0);
    push_word(-1, 0, 0);
    // step 16 at pos 0: exact halves round away from zero
    push_word(8, 0, 0);
    push_word(-8, 0, 0);
    push_word(24, 0, 0);
    push_word(-24, 0, 0);
    push_word(7, 0, 0);
    push_word(-7, 0, 0);
    // step 10 at pos 2
    push_word(5, 2, 0);
    push_word(-5, 2, 0);
    push_word(15, 2, 0);
    push_word(-15, 2, 0);
    push_word(4, 2, 0);
    push_word(1023, 37, 0);
    push_word(-1024, 53, 0);
    push_word(-9, 0, 1);

    for (k = 0; k <= quality_plan.size(); k++) begin
      if (k > 0) begin
        // quality only changes with nothing in flight
        while (coeff_backlog.size() != 0 || want_levels.size() != 0 || s_axis_tvalid)
          @(posedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
        cfg_we_i <= 1'b1;
        cfg_wdata_i <= quality_plan[k-1][jqq_pkg::Q_W-1:0];
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
        quality_shadow = quality_plan[k-1][jqq_pkg::Q_W-1:0];
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        case ($urandom_range(0, 7))
          0, 1:    coef = int'($urandom_range(0, 128)) - 64;
          2:       coef = $urandom_range(0, 1) ? LVL_MAX : LVL_MIN;
          default: coef = int'($urandom_range(0, 2047)) - 1024;
        endcase
        push_word(coef, $urandom_range(0, 63), $urandom_range(0, 1));
      end
      phases_run++;
    end

    while (coeff_backlog.size() != 0 || want_levels.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d coefficient words over %0d quality settings, incl. 0, 1, 49..51, 100, 127",
             words_sent, phases_run);
    $display("%0d levels checked, %0d mismatches", levels_checked, mismatches);
    if (mismatches == 0 && want_levels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // table rebuilds after each quality write dominate; this is several times the slowest run
  initial begin
    #6_000_000;
    $display("timeout: %0d words still queued, %0d levels outstanding",
             coeff_backlog.size(), want_levels.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
